@@ src/gda_pkg.sv @@
// Shared types, constants and calendar functions for the date adder.
package gda_pkg;

  // Calendar limits and field widths
  localparam int MAX_YEAR    = 9999;
  localparam int OFFSET_BITS = 20;
  localparam int DAY_W       = 5;
  localparam int MONTH_W     = 4;
  localparam int YEAR_W      = 14;
  localparam int OFF_W       = 20;
  localparam int DOY_W       = 9;
  localparam int REM_W       = ((OFFSET_BITS > DOY_W) ? OFFSET_BITS : DOY_W) + 1;
  localparam int CYCLE_YEARS = 400;

  localparam logic [MONTH_W-1:0] JANUARY  = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] FEBRUARY = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] DECEMBER = MONTH_W'(12);

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_INIT,
    S_YEAR,
    S_MONTH,
    S_DONE
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    logic reduce;
    logic init;
    logic year_step;
    logic month_step;
    logic saturate;
  } ctrl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic reduce_done;
    logic year_fits;
    logic at_max;
    logic month_fits;
  } dp_status_t;

  // Leap test on a year already reduced modulo 400
  function automatic logic is_leap(input logic [DOY_W-1:0] r);
    logic [DOY_W-1:0] r100;
    if (r >= DOY_W'(300)) begin
      r100 = r - DOY_W'(300);
    end else if (r >= DOY_W'(200)) begin
      r100 = r - DOY_W'(200);
    end else if (r >= DOY_W'(100)) begin
      r100 = r - DOY_W'(100);
    end else begin
      r100 = r;
    end
    return (r[1:0] == 2'd0) && ((r100 != '0) || (r == '0));
  endfunction

  // Length of a month, with February at 29 days in a leap year
  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_W'(31);
      4'd4, 4'd6, 4'd9, 4'd11:                    len = DAY_W'(30);
      4'd2:                                        len = leap ? DAY_W'(29) : DAY_W'(28);
      default:                                     len = DAY_W'(31);
    endcase
    return len;
  endfunction

  // Days in the months before month m of a common year
  function automatic logic [DOY_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
    logic [DOY_W-1:0] acc;
    unique case (m)
      4'd1:    acc = DOY_W'(0);
      4'd2:    acc = DOY_W'(31);
      4'd3:    acc = DOY_W'(59);
      4'd4:    acc = DOY_W'(90);
      4'd5:    acc = DOY_W'(120);
      4'd6:    acc = DOY_W'(151);
      4'd7:    acc = DOY_W'(181);
      4'd8:    acc = DOY_W'(212);
      4'd9:    acc = DOY_W'(243);
      4'd10:   acc = DOY_W'(273);
      4'd11:   acc = DOY_W'(304);
      4'd12:   acc = DOY_W'(334);
      default: acc = DOY_W'(0);
    endcase
    return acc;
  endfunction

endpackage

@@ src/gregorian_date_add_days.sv @@
// Top level of the Gregorian date adder: controller plus datapath.
//
// Raise start while busy is low to present a date and a day offset; the word
// is taken at that edge and busy rises at once. The result appears for one
// cycle with done high and cannot be held off, so capture it then; busy
// falls the cycle after. After the accepting edge the controller reduces the
// clamped start year modulo 400, one subtraction a cycle, then forms the
// day of year plus the offset, walks the years at one year per cycle (about
// 2900 year boundaries at most for the largest offset) and then walks the
// months of the final year (at most 11 month steps). A saturated result
// skips the month walk. Out-of-range start fields are clamped; a result past
// December 31 of the last year saturates to that date with year_overflow.
module gregorian_date_add_days (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [gda_pkg::DAY_W-1:0]   start_day,
  input  logic [gda_pkg::MONTH_W-1:0] start_month,
  input  logic [gda_pkg::YEAR_W-1:0]  start_year,
  input  logic [gda_pkg::OFF_W-1:0]   day_offset,
  output logic                        done,
  output logic [gda_pkg::DAY_W-1:0]   end_day,
  output logic [gda_pkg::MONTH_W-1:0] end_month,
  output logic [gda_pkg::YEAR_W-1:0]  end_year,
  output logic                        year_overflow
);
  import gda_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Sequence the walk
  gda_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  // Hold and walk the date
  gda_dp u_dp (
    .clk           (clk),
    .cmd           (cmd),
    .start_day     (start_day),
    .start_month   (start_month),
    .start_year    (start_year),
    .day_offset    (day_offset),
    .status        (status),
    .end_day       (end_day),
    .end_month     (end_month),
    .end_year      (end_year),
    .year_overflow (year_overflow)
  );

`ifndef NO_ASSERTIONS
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("done raised while idle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted word did not start a walk");

  a_saturate: assert property (@(posedge clk) disable iff (rst)
    (done && year_overflow) |-> ((end_month == DECEMBER) && (end_day == DAY_W'(31))
                                  && (end_year == YEAR_W'(MAX_YEAR))))
    else $error("overflow result not saturated");

  a_month_range: assert property (@(posedge clk) disable iff (rst)
    done |-> ((end_month >= JANUARY) && (end_month <= DECEMBER) && (end_day != '0)))
    else $error("result date out of range");
`endif

endmodule

@@ src/gda_ctrl.sv @@
// Controller state machine that sequences the date walk.
module gda_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  gda_pkg::dp_status_t status,
  output gda_pkg::ctrl_cmd_t  cmd,
  output logic                busy,
  output logic                done
);
  import gda_pkg::*;

  state_t state;
  state_t state_next;

  // Hold the state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Choose the next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_REDUCE;
      end
      S_REDUCE: begin
        if (status.reduce_done) state_next = S_INIT;
      end
      S_INIT: begin
        state_next = S_YEAR;
      end
      S_YEAR: begin
        if (status.year_fits) begin
          state_next = S_MONTH;
        end else if (status.at_max) begin
          state_next = S_DONE;
        end
      end
      S_MONTH: begin
        if (status.month_fits) state_next = S_DONE;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Drive commands and handshake outputs
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    done = 1'b0;
    unique case (state)
      S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      S_REDUCE: begin
        cmd.reduce = !status.reduce_done;
      end
      S_INIT: begin
        cmd.init = 1'b1;
      end
      S_YEAR: begin
        if (!status.year_fits) begin
          if (status.at_max) begin
            cmd.saturate = 1'b1;
          end else begin
            cmd.year_step = 1'b1;
          end
        end
      end
      S_MONTH: begin
        cmd.month_step = !status.month_fits;
      end
      S_DONE: begin
        done = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

@@ src/gda_dp.sv @@
// Datapath: input clamping, year-cycle reduction and the year and month walk.
module gda_dp (
  input  logic                              clk,
  input  gda_pkg::ctrl_cmd_t                cmd,
  input  logic [gda_pkg::DAY_W-1:0]         start_day,
  input  logic [gda_pkg::MONTH_W-1:0]       start_month,
  input  logic [gda_pkg::YEAR_W-1:0]        start_year,
  input  logic [gda_pkg::OFF_W-1:0]         day_offset,
  output gda_pkg::dp_status_t               status,
  output logic [gda_pkg::DAY_W-1:0]         end_day,
  output logic [gda_pkg::MONTH_W-1:0]       end_month,
  output logic [gda_pkg::YEAR_W-1:0]        end_year,
  output logic                              year_overflow
);
  import gda_pkg::*;

  localparam logic [YEAR_W-1:0] MAX_Y = YEAR_W'(MAX_YEAR);
  localparam logic [YEAR_W-1:0] CYC   = YEAR_W'(CYCLE_YEARS);

  logic [DAY_W-1:0]       day;
  logic [MONTH_W-1:0]     month;
  logic [YEAR_W-1:0]      year;
  logic [YEAR_W-1:0]      ymod;
  logic [OFFSET_BITS-1:0] off;
  logic [REM_W-1:0]       rem;
  logic                   ovf;

  logic                   leap;
  logic [DAY_W-1:0]       start_len;
  logic [DAY_W-1:0]       day_clamped;
  logic [DOY_W-1:0]       doy;
  logic [REM_W-1:0]       year_len;
  logic [REM_W-1:0]       mon_len;
  logic [MONTH_W-1:0]     month_in;
  logic [YEAR_W-1:0]      year_in;

  // Clamp the incoming month and year
  always_comb begin
    if (start_month == '0) begin
      month_in = JANUARY;
    end else if (start_month > DECEMBER) begin
      month_in = DECEMBER;
    end else begin
      month_in = start_month;
    end
    if (start_year == '0) begin
      year_in = YEAR_W'(1);
    end else if (start_year > MAX_Y) begin
      year_in = MAX_Y;
    end else begin
      year_in = start_year;
    end
  end

  // Leap flag of the current year, valid once ymod is below 400
  assign leap = is_leap(ymod[DOY_W-1:0]);

  // Clamp the start day and form its day of year
  always_comb begin
    start_len = month_days(month, leap);
    if (day == '0) begin
      day_clamped = DAY_W'(1);
    end else if (day > start_len) begin
      day_clamped = start_len;
    end else begin
      day_clamped = day;
    end
    doy = days_before_month(month) + DOY_W'(day_clamped)
        + DOY_W'(leap && (month > FEBRUARY));
  end

  // Lengths used by the walk
  assign year_len = leap ? REM_W'(366) : REM_W'(365);
  assign mon_len  = REM_W'(month_days(month, leap));

  // Report status to the controller
  assign status.reduce_done = (ymod < CYC);
  assign status.year_fits   = (rem <= year_len);
  assign status.at_max      = (year == MAX_Y);
  assign status.month_fits  = (month == DECEMBER) || (rem <= mon_len);

  // Load, reduce and walk
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      day   <= start_day;
      month <= month_in;
      year  <= year_in;
      ymod  <= year_in;
      off   <= day_offset[OFFSET_BITS-1:0];
    end
    if (cmd.reduce) begin
      ymod <= ymod - CYC;
    end
    if (cmd.init) begin
      rem   <= REM_W'(doy) + REM_W'(off);
      month <= JANUARY;
      ovf   <= 1'b0;
    end
    if (cmd.year_step) begin
      rem  <= rem - year_len;
      year <= year + YEAR_W'(1);
      ymod <= (ymod == CYC - YEAR_W'(1)) ? '0 : ymod + YEAR_W'(1);
    end
    if (cmd.month_step) begin
      rem   <= rem - mon_len;
      month <= month + MONTH_W'(1);
    end
    if (cmd.saturate) begin
      rem   <= REM_W'(31);
      month <= DECEMBER;
      ovf   <= 1'b1;
    end
  end

  // Present the result
  assign end_day       = rem[DAY_W-1:0];
  assign end_month     = month;
  assign end_year      = year;
  assign year_overflow = ovf;

endmodule

@@ sim/tb_gregorian_date_add_days.sv @@
// Self-checking testbench for the Gregorian date adder: directed and random date words.
`timescale 1ns / 1ps

module tb_gregorian_date_add_days;

  import gda_pkg::*;

  // One date word as presented to the adder
  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic [OFF_W-1:0]   offset;
  } date_req_t;

  // One resulting date as returned by the adder
  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic               overflow;
  } date_res_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic [DAY_W-1:0]     start_day = '0;
  logic [MONTH_W-1:0]   start_month = '0;
  logic [YEAR_W-1:0]    start_year = '0;
  logic [OFF_W-1:0]     day_offset = '0;
  logic                 done;
  logic [DAY_W-1:0]     end_day;
  logic [MONTH_W-1:0]   end_month;
  logic [YEAR_W-1:0]    end_year;
  logic                 year_overflow;

  date_req_t pending_words[$];
  date_res_t expected_dates[$];
  int        failures = 0;
  int        hold_off = 0;
  bit        no_idle = 1'b0;

  gregorian_date_add_days u_dut (.*);

  // Free-running clock, 2 ns period
  initial begin
    forever #1 clk = ~clk;
  end

  // Leap rule: every fourth year, but not centuries unless divisible by 400
  function automatic bit leap_year(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned month_length(int unsigned y, int unsigned m);
    case (m)
      4, 6, 9, 11: return 30;
      2:           return leap_year(y) ? 29 : 28;
      default:     return 31;
    endcase
  endfunction

  // Day count from January 1 of year 1, which is day 1
  function automatic longint unsigned serial_number(int unsigned y, int unsigned m,
                                                    int unsigned d);
    longint unsigned p;
    longint unsigned s;
    p = y - 1;
    s = 365 * p + p / 4 - p / 100 + p / 400;
    for (int unsigned i = 1; i < m; i++) s += month_length(y, i);
    return s + d;
  endfunction

  // Predict the date that lies the given number of days after the start date
  function automatic date_res_t add_days(date_req_t w);
    int unsigned     d;
    int unsigned     m;
    int unsigned     y;
    int unsigned     len;
    longint unsigned total;
    date_res_t       r;
    // clamp the start fields into a real date
    m = w.month;
    if (m < 1) m = 1;
    if (m > 12) m = 12;
    y = w.year;
    if (y < 1) y = 1;
    if (y > MAX_YEAR) y = MAX_YEAR;
    d = w.day;
    if (d < 1) d = 1;
    len = month_length(y, m);
    if (d > len) d = len;
    total = serial_number(y, m, d) +
            (longint'(w.offset) & ((longint'(1) << OFFSET_BITS) - 1));
    // saturate past the last day of the last year
    if (total > serial_number(MAX_YEAR, 12, 31)) begin
      r.day      = DAY_W'(31);
      r.month    = MONTH_W'(12);
      r.year     = YEAR_W'(MAX_YEAR);
      r.overflow = 1'b1;
      return r;
    end
    // walk whole years, then months within the final year
    y = 1;
    while (total > (leap_year(y) ? 366 : 365)) begin
      total -= leap_year(y) ? 366 : 365;
      y++;
    end
    m = 1;
    while (m < 12 && total > month_length(y, m)) begin
      total -= month_length(y, m);
      m++;
    end
    r.day      = DAY_W'(total);
    r.month    = MONTH_W'(m);
    r.year     = YEAR_W'(y);
    r.overflow = 1'b0;
    return r;
  endfunction

  task automatic queue_date(int unsigned d, int unsigned m, int unsigned y,
                            int unsigned off);
    date_req_t w;
    w.day    = DAY_W'(d);
    w.month  = MONTH_W'(m);
    w.year   = YEAR_W'(y);
    w.offset = OFF_W'(off);
    pending_words.push_back(w);
  endtask

  // Driver: present pending words, record the prediction on each accepted one
  always @(posedge clk) begin
    date_req_t nxt;
    logic      raise;
    if (rst) begin
      start <= 1'b0;
    end else begin
      raise = start;
      if (start && !busy) begin
        nxt.day    = start_day;
        nxt.month  = start_month;
        nxt.year   = start_year;
        nxt.offset = day_offset;
        expected_dates.push_back(add_days(nxt));
        raise = 1'b0;
        // switch now and then between back-to-back bursts and random gaps
        if ($urandom_range(0, 9) == 0) no_idle = !no_idle;
        hold_off = no_idle ? 0 : $urandom_range(0, 19);
      end
      if (!raise) begin
        if (hold_off > 0) begin
          hold_off--;
        end else if (pending_words.size() > 0) begin
          nxt = pending_words.pop_front();
          start_day   <= nxt.day;
          start_month <= nxt.month;
          start_year  <= nxt.year;
          day_offset  <= nxt.offset;
          raise = 1'b1;
        end
      end
      start <= raise;
    end
  end

  // Monitor: compare each strobed result with the oldest prediction
  always @(posedge clk) begin
    date_res_t want;
    if (!rst && done) begin
      if (expected_dates.size() == 0) begin
        $error("result %0d/%0d/%0d with no word outstanding", end_day, end_month, end_year);
        failures++;
      end else begin
        want = expected_dates.pop_front();
        if (end_day !== want.day) begin
          $error("end_day: expected %0d, got %0d", want.day, end_day);
          failures++;
        end
        if (end_month !== want.month) begin
          $error("end_month: expected %0d, got %0d", want.month, end_month);
          failures++;
        end
        if (end_year !== want.year) begin
          $error("end_year: expected %0d, got %0d", want.year, end_year);
          failures++;
        end
        if (year_overflow !== want.overflow) begin
          $error("year_overflow: expected %0d, got %0d", want.overflow, year_overflow);
          failures++;
        end
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int unsigned y;
    int unsigned m;
    int unsigned d;
    int unsigned off;
    int unsigned sel;

    // extremes of range and of the calendar
    queue_date(1, 1, 1, 0);
    queue_date(31, 12, MAX_YEAR, 0);
    queue_date(31, 12, MAX_YEAR, 1);
    queue_date(1, 1, 1, 20'hFFFFF);
    queue_date(1, 1, MAX_YEAR, 20'hFFFFF);
    queue_date(1, 1, MAX_YEAR - 2, 1094);
    queue_date(1, 1, MAX_YEAR - 2, 1095);
    // out-of-range start fields get clamped
    queue_date(15, 0, 2000, 10);
    queue_date(15, 13, 2001, 20);
    queue_date(31, 15, 16383, 0);
    queue_date(10, 6, 0, 100);
    queue_date(10, 6, 12000, 0);
    queue_date(0, 3, 1999, 5);
    queue_date(0, 0, 0, 0);
    queue_date(31, 2, 2000, 0);
    queue_date(30, 2, 1900, 0);
    queue_date(31, 4, 2023, 1);
    // leap day and year boundaries
    queue_date(28, 2, 2024, 1);
    queue_date(29, 2, 2024, 1);
    queue_date(31, 12, 1999, 1);
    queue_date(28, 2, 2100, 1);
    queue_date(1, 1, 2023, 365);
    queue_date(31, 12, 2023, 366);
    queue_date(16, 8, 4321, 20'h5A5A5);

    // random words: mostly real dates, the rest raw field bits
    repeat (76) begin
      sel = $urandom_range(0, 9);
      if (sel < 7) begin
        y = $urandom_range(1, MAX_YEAR);
        m = $urandom_range(1, 12);
        d = $urandom_range(1, month_length(y, m));
        case ($urandom_range(0, 2))
          0:       off = $urandom_range(0, 400);
          1:       off = $urandom_range(0, 40000);
          default: off = $urandom & 32'hFFFFF;
        endcase
      end else begin
        d   = $urandom & 32'h1F;
        m   = $urandom & 32'hF;
        y   = $urandom & 32'h3FFF;
        off = $urandom & 32'hFFFFF;
      end
      queue_date(d, m, y, off);
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // drain, then allow a margin for any stray strobe
    while (pending_words.size() != 0 || start || busy || expected_dates.size() != 0)
      @(posedge clk);
    repeat (50) @(posedge clk);
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #4000000;
    $display("simulation failed");
    $finish;
  end

endmodule
